### rtl/core/mueuf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mueuf_pkg: shared types and constants of the unique edge filter
// Index widths, epoch width, sequencer states and the probe status bundle.
// ----------------------------------------------------------------------------
package mueuf_pkg;

  localparam int IDX_W   = 10;  // vertex index width of the corner and edge fields
  localparam int CFG_W   = 11;  // width of the vertex count register
  localparam int EPOCH_W = 8;   // mesh generation tag kept in every table row

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_PROBE,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic found;  // edge already present in the row
    logic full;   // row holds MAX_DEGREE neighbours
  } probe_stat_t;

endpackage

### rtl/core/mesh_unique_edge_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_unique_edge_filter_core: unique edge filter for triangle meshes
// Emits each edge of a triangle stream once per mesh while its low vertex's row
// has room, using a per-vertex neighbour table held in one RAM row per vertex.
// ----------------------------------------------------------------------------
//  channel | signals                                       | dir | beat
//  --------+-----------------------------------------------+-----+-------------------
//  in      | in_start_mesh, in_corner_a/b/c                | in  | one triangle
//  out     | out_end_low, out_end_high, out_last,          | out | one new edge
//          | out_not_recorded                              |     |
//  cfg     | cfg_vertex_count                              | in  | vertex count write
//
// Steps: each triangle has an accept step, then per edge either a skip step or
//   a read step plus a probe/write-back step through the single RAM port pair,
//   then a flush step for the last result.
// Rows carry a mesh epoch tag, so start_mesh clears the table by bumping the
//   epoch; every 2**EPOCH_W-th start_mesh the tag wraps and a sweep rewrites
//   all rows before that triangle is handled.
// Reset: a sweep clears the table; in_ready stays low then.
// Stalls: a held result waits in the output register; the probe holds while a
//   new edge meets a pending result and an occupied, stalled output register.
// ----------------------------------------------------------------------------
module mesh_unique_edge_filter_core
  import mueuf_pkg::*;
#(
  parameter int VERTICES   = 1024,
  parameter int MAX_DEGREE = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_vertex_count,
  // triangle input
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_start_mesh,
  input  logic [IDX_W-1:0] in_corner_a,
  input  logic [IDX_W-1:0] in_corner_b,
  input  logic [IDX_W-1:0] in_corner_c,
  // edge output
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_end_low,
  output logic [IDX_W-1:0] out_end_high,
  output logic             out_last,
  output logic             out_not_recorded
);

  localparam int V_AW   = $clog2(VERTICES);
  localparam int CW     = $clog2(MAX_DEGREE + 1);
  localparam int ROW_W  = MAX_DEGREE * IDX_W;
  localparam int WORD_W = EPOCH_W + CW + ROW_W;
  localparam logic [V_AW-1:0] LAST_ADDR = V_AW'(VERTICES - 1);

  localparam logic [1:0] EDGE_CA = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_AB = 2'd2;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   vcount_r;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [V_AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic               tri_hold_r, tri_hold_nxt;   // triangle waits behind a sweep
  logic [1:0]         edge_r, edge_nxt;
  logic [IDX_W-1:0]   ca_r, cb_r, cc_r;
  logic [IDX_W-1:0]   lo_r, hi_r, lo_nxt, hi_nxt;

  // result held back until it is known whether it is the triangle's last
  logic               pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]   pend_lo_r, pend_hi_r, pend_lo_nxt, pend_hi_nxt;
  logic               pend_nr_r, pend_nr_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]   out_lo_r, out_hi_r, out_lo_nxt, out_hi_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_nr_r, out_nr_nxt;

  // --------------------------------------------------------------------------
  // Edge selection for the current step: order endpoints, test the bounds
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0] e_first, e_second, e_lo, e_hi;
  logic             e_skip;
  logic [31:0]      e_lo_ext, lo_ext;

  always_comb begin
    case (edge_r)
      EDGE_CA: begin
        e_first  = cc_r;
        e_second = ca_r;
      end
      EDGE_BC: begin
        e_first  = cb_r;
        e_second = cc_r;
      end
      EDGE_AB: begin
        e_first  = ca_r;
        e_second = cb_r;
      end
      default: begin
        e_first  = ca_r;
        e_second = cb_r;
      end
    endcase
    if (e_first > e_second) begin
      e_lo = e_second;
      e_hi = e_first;
    end else begin
      e_lo = e_first;
      e_hi = e_second;
    end
  end

  assign e_skip   = (CFG_W'(e_hi) >= vcount_r) || (32'(e_hi) >= 32'(VERTICES));
  assign e_lo_ext = 32'(e_lo);
  assign lo_ext   = 32'(lo_r);

  // --------------------------------------------------------------------------
  // Neighbour table and shared probe
  // --------------------------------------------------------------------------
  logic              ram_we, ram_re;
  logic [V_AW-1:0]   ram_waddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata, probe_word;
  probe_stat_t       pstat;

  mueuf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (VERTICES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (e_lo_ext[V_AW-1:0]),
    .rdata (ram_rdata)
  );

  mueuf_probe #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_probe (
    .rd_word (ram_rdata),
    .epoch   (epoch_r),
    .hi      (hi_r),
    .stat    (pstat),
    .wr_word (probe_word)
  );

  // --------------------------------------------------------------------------
  // Handshake helpers
  // --------------------------------------------------------------------------
  logic in_fire, slot_free, emit, probe_go, last_edge;

  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign emit      = !pstat.found;
  // hold the probe only when the new edge would displace a pending result
  // that has nowhere to go
  assign probe_go  = !emit || !pend_valid_r || slot_free;
  assign last_edge = (edge_r == EDGE_AB);

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = tri_hold_r ? S_LOOK : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_start_mesh && (epoch_r == '1)) ? S_CLEAR : S_LOOK;
        end
      end
      S_LOOK: begin
        if (!e_skip) begin
          state_nxt = S_PROBE;
        end else if (last_edge) begin
          state_nxt = S_FLUSH;
        end
      end
      S_PROBE: begin
        if (probe_go) begin
          state_nxt = last_edge ? S_FLUSH : S_LOOK;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_r || slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs and datapath updates
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready       = (state_r == S_IDLE);
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = lo_ext[V_AW-1:0];
    ram_wdata      = probe_word;
    epoch_nxt      = epoch_r;
    clr_addr_nxt   = clr_addr_r;
    tri_hold_nxt   = tri_hold_r;
    edge_nxt       = edge_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    pend_valid_nxt = pend_valid_r;
    pend_lo_nxt    = pend_lo_r;
    pend_hi_nxt    = pend_hi_r;
    pend_nr_nxt    = pend_nr_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    out_lo_nxt     = out_lo_r;
    out_hi_nxt     = out_hi_r;
    out_last_nxt   = out_last_r;
    out_nr_nxt     = out_nr_r;

    case (state_r)
      S_CLEAR: begin
        // rewrite one row a cycle as empty with epoch zero
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        clr_addr_nxt = clr_addr_r + V_AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          clr_addr_nxt = '0;
          tri_hold_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        edge_nxt = EDGE_CA;
        if (in_fire && in_start_mesh) begin
          // a new mesh: bump the epoch, sweep the table when the tag wraps
          epoch_nxt = epoch_r + EPOCH_W'(1);
          if (epoch_r == '1) begin
            tri_hold_nxt = 1'b1;
            clr_addr_nxt = '0;
          end
        end
      end
      S_LOOK: begin
        lo_nxt = e_lo;
        hi_nxt = e_hi;
        if (!e_skip) begin
          ram_re = 1'b1;
        end else if (!last_edge) begin
          edge_nxt = edge_r + 2'd1;
        end
      end
      S_PROBE: begin
        if (probe_go) begin
          if (!last_edge) begin
            edge_nxt = edge_r + 2'd1;
          end
          if (emit) begin
            ram_we = !pstat.full;
            // advance the pending result to the output, not last
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_lo_nxt    = pend_lo_r;
              out_hi_nxt    = pend_hi_r;
              out_last_nxt  = 1'b0;
              out_nr_nxt    = pend_nr_r;
            end
            pend_valid_nxt = 1'b1;
            pend_lo_nxt    = lo_r;
            pend_hi_nxt    = hi_r;
            pend_nr_nxt    = pstat.full;
          end
        end
      end
      S_FLUSH: begin
        if (pend_valid_r && slot_free) begin
          out_valid_nxt  = 1'b1;
          out_lo_nxt     = pend_lo_r;
          out_hi_nxt     = pend_hi_r;
          out_last_nxt   = 1'b1;
          out_nr_nxt     = pend_nr_r;
          pend_valid_nxt = 1'b0;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      vcount_r     <= '0;
      epoch_r      <= '0;
      clr_addr_r   <= '0;
      tri_hold_r   <= 1'b0;
      edge_r       <= EDGE_CA;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      epoch_r      <= epoch_nxt;
      clr_addr_r   <= clr_addr_nxt;
      tri_hold_r   <= tri_hold_nxt;
      edge_r       <= edge_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        vcount_r <= cfg_vertex_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ca_r <= in_corner_a;
      cb_r <= in_corner_b;
      cc_r <= in_corner_c;
    end
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    pend_lo_r <= pend_lo_nxt;
    pend_hi_r <= pend_hi_nxt;
    pend_nr_r <= pend_nr_nxt;
    out_lo_r  <= out_lo_nxt;
    out_hi_r  <= out_hi_nxt;
    out_last_r <= out_last_nxt;
    out_nr_r  <= out_nr_nxt;
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_end_low      = out_lo_r;
  assign out_end_high     = out_hi_r;
  assign out_last         = out_last_r;
  assign out_not_recorded = out_nr_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_valid_r)
    else $error("triangle accepted while a result is still pending");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_PROBE))
    else $error("table written outside sweep or probe");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && (state_r == S_PROBE || state_r == S_FLUSH))
      |=> ($stable(out_lo_r) && $stable(out_hi_r) && $stable(out_last_r)))
    else $error("stalled output beat overwritten");

  a_wrap_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_start_mesh && (epoch_r == '1)) |=> (state_r == S_CLEAR))
    else $error("epoch wrap did not start a table sweep");

endmodule

### rtl/core/mueuf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mueuf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mueuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/mueuf_probe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mueuf_probe: shared neighbour row probe
// Matches one high endpoint against a row and builds the appended row.
// ----------------------------------------------------------------------------
module mueuf_probe
  import mueuf_pkg::*;
#(
  parameter int MAX_DEGREE = 8,
  localparam int CW     = $clog2(MAX_DEGREE + 1),
  localparam int ROW_W  = MAX_DEGREE * IDX_W,
  localparam int WORD_W = EPOCH_W + CW + ROW_W
) (
  input  logic [WORD_W-1:0]  rd_word,
  input  logic [EPOCH_W-1:0] epoch,
  input  logic [IDX_W-1:0]   hi,
  output probe_stat_t        stat,
  output logic [WORD_W-1:0]  wr_word
);

  logic [EPOCH_W-1:0]    row_epoch;
  logic [CW-1:0]         cnt;
  logic [MAX_DEGREE-1:0] hit;
  logic [ROW_W-1:0]      row_new;

  assign row_epoch = rd_word[WORD_W-1 -: EPOCH_W];
  // a row tagged with an older mesh counts as empty
  assign cnt = (row_epoch == epoch) ? rd_word[ROW_W +: CW] : '0;

  always_comb begin
    for (int k = 0; k < MAX_DEGREE; k++) begin
      hit[k] = (CW'(k) < cnt) && (rd_word[k*IDX_W +: IDX_W] == hi);
      row_new[k*IDX_W +: IDX_W] = (CW'(k) == cnt) ? hi : rd_word[k*IDX_W +: IDX_W];
    end
  end

  assign stat.found = |hit;
  assign stat.full  = (cnt >= CW'(MAX_DEGREE));
  assign wr_word    = {epoch, CW'(cnt + CW'(1)), row_new};

endmodule
